/* hw/rtl/fpr_pkg.sv */
// types and constants shared by the fifo page replacement block
package fpr_pkg;

    localparam int MAX_RESULTS = 16;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_EVICT  = 2'd2,
        OP_ACCESS = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_DUP    = 2'd1,
        ST_FULL   = 2'd2,
        ST_ABSENT = 2'd3
    } t_status;

    typedef struct packed {
        t_op         op;
        logic [15:0] page_id;
        logic [3:0]  frame_index;
        logic [4:0]  count;
    } t_in;

    typedef struct packed {
        logic [3:0] evicted_frame;
        logic       has_frame;
        logic       last;
        t_status    status;
        logic [4:0] occupancy;
    } t_out;

    typedef struct packed {
        logic [15:0] page_id;
        logic [3:0]  frame_index;
    } t_slot;

endpackage

/* hw/rtl/fifo_page_replacement.sv */
// fifo page replacement queue: circular slot memory with search, shift and evict sweeps
// one item at a time; input stall is high from acceptance until the last result is queued
// insert: one slot compare per cycle through the slot memory read port
// remove: slots behind the page move one per cycle
// evict oldest: one frame read and one result per cycle without output stall
// reset clears the page count, head pointer and output valid; slot memory is not cleared
module fifo_page_replacement
    import fpr_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_item,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_item
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    localparam int KW = (CW > 5) ? CW : 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_EV_RD,
        S_EV_OUT,
        S_RESP
    } t_state;

    function automatic logic [IW-1:0] f_phys(logic [IW-1:0] head, logic [CW-1:0] l);
        logic [IW:0] sum;
        sum = (IW+1)'(head) + (IW+1)'(l);
        if (sum >= (IW+1)'(FRAMES)) begin
            sum = sum - (IW+1)'(FRAMES);
        end
        return sum[IW-1:0];
    endfunction

    t_slot          r_mem [FRAMES];
    t_slot          r_rdata;
    t_state         r_state;
    t_in            r_item;
    t_status        r_status;
    t_out           r_out;
    logic           r_out_valid;
    logic [CW-1:0]  r_held;
    logic [IW-1:0]  r_head;
    logic [CW-1:0]  r_idx;
    logic [CW-1:0]  r_cmp_idx;
    logic           r_cmp_vld;
    logic [CW-1:0]  r_take;

    logic           accept;
    logic           out_free;
    logic           match;
    logic           more;
    logic           ev_last;
    logic [KW-1:0]  take_a;
    logic [KW-1:0]  take_b;
    logic [CW-1:0]  take;
    logic           mem_re;
    logic [IW-1:0]  mem_ra;
    logic           mem_we;
    logic [IW-1:0]  mem_wa;
    t_slot          mem_wd;

    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    assign match    = r_cmp_vld && (r_rdata.page_id == r_item.page_id);
    assign more     = r_idx < r_held;
    assign ev_last  = CW'(r_idx + 1'b1) == r_take;

    assign take_a = (KW'(i_in_item.count) > KW'(r_held)) ? KW'(r_held) : KW'(i_in_item.count);
    assign take_b = (take_a > KW'(MAX_RESULTS)) ? KW'(MAX_RESULTS) : take_a;
    assign take   = CW'(take_b);

    always_comb begin
        mem_re = 1'b0;
        mem_ra = '0;
        mem_we = 1'b0;
        mem_wa = '0;
        mem_wd = t_slot'{page_id: r_item.page_id, frame_index: r_item.frame_index};
        case (r_state)
            S_SEARCH: begin
                if (!match && more) begin
                    mem_re = 1'b1;
                    mem_ra = f_phys(r_head, r_idx);
                end
                if (!match && !more && (r_item.op == OP_INSERT)
                        && (r_held < CW'(FRAMES))) begin
                    mem_we = 1'b1;
                    mem_wa = f_phys(r_head, r_held);
                end
            end
            S_SHIFT: begin
                if (more) begin
                    mem_re = 1'b1;
                    mem_ra = f_phys(r_head, r_idx);
                end
                if (r_cmp_vld) begin
                    mem_we = 1'b1;
                    mem_wa = f_phys(r_head, CW'(r_cmp_idx - 1'b1));
                    mem_wd = r_rdata;
                end
            end
            S_EV_RD: begin
                mem_re = 1'b1;
                mem_ra = f_phys(r_head, r_idx);
            end
            S_EV_OUT: begin
                if (out_free && !ev_last) begin
                    mem_re = 1'b1;
                    mem_ra = f_phys(r_head, CW'(r_idx + 1'b1));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_held      <= '0;
            r_head      <= '0;
            r_cmp_vld   <= 1'b0;
        end else begin
            if (out_free && (r_state != S_EV_OUT) && (r_state != S_RESP)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_cmp_vld <= 1'b0;
                    r_idx     <= '0;
                    if (accept) begin
                        r_item <= i_in_item;
                        case (i_in_item.op)
                            OP_INSERT, OP_REMOVE: begin
                                r_state <= S_SEARCH;
                            end
                            OP_EVICT: begin
                                r_take <= take;
                                if (take == '0) begin
                                    r_status <= ST_OK;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state <= S_EV_RD;
                                end
                            end
                            OP_ACCESS: begin
                                r_status <= ST_OK;
                                r_state  <= S_RESP;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_RESP;
                            end
                        endcase
                    end
                end
                S_SEARCH: begin
                    if (match) begin
                        if (r_item.op == OP_INSERT) begin
                            r_status <= ST_DUP;
                            r_state  <= S_RESP;
                        end else begin
                            r_idx     <= CW'(r_cmp_idx + 1'b1);
                            r_cmp_vld <= 1'b0;
                            r_state   <= S_SHIFT;
                        end
                    end else if (more) begin
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_idx;
                        r_idx     <= CW'(r_idx + 1'b1);
                    end else begin
                        if (r_item.op == OP_INSERT) begin
                            if (r_held < CW'(FRAMES)) begin
                                r_held   <= CW'(r_held + 1'b1);
                                r_status <= ST_OK;
                            end else begin
                                r_status <= ST_FULL;
                            end
                        end else begin
                            r_status <= ST_ABSENT;
                        end
                        r_state <= S_RESP;
                    end
                end
                S_SHIFT: begin
                    if (more) begin
                        r_cmp_vld <= 1'b1;
                        r_cmp_idx <= r_idx;
                        r_idx     <= CW'(r_idx + 1'b1);
                    end else begin
                        r_cmp_vld <= 1'b0;
                        r_held    <= CW'(r_held - 1'b1);
                        r_status  <= ST_OK;
                        r_state   <= S_RESP;
                    end
                end
                S_EV_RD: begin
                    r_state <= S_EV_OUT;
                end
                S_EV_OUT: begin
                    if (out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out.evicted_frame <= r_rdata.frame_index;
                        r_out.has_frame     <= 1'b1;
                        r_out.last          <= ev_last;
                        r_out.status        <= ST_OK;
                        r_out.occupancy     <= 5'(r_held - r_take);
                        if (ev_last) begin
                            r_head  <= f_phys(r_head, r_take);
                            r_held  <= CW'(r_held - r_take);
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= CW'(r_idx + 1'b1);
                        end
                    end
                end
                S_RESP: begin
                    if (out_free) begin
                        r_out_valid         <= 1'b1;
                        r_out.evicted_frame <= '0;
                        r_out.has_frame     <= 1'b0;
                        r_out.last          <= 1'b1;
                        r_out.status        <= r_status;
                        r_out.occupancy     <= 5'(r_held);
                        r_state             <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= CW'(FRAMES))
        else $error("page count above frame count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after item accepted");

    a_no_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("slot memory read and write hit the same entry");

    a_evict_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EV_RD) || (r_state == S_EV_OUT))
            |-> ((r_take != '0) && (r_take <= r_held) && (r_idx < r_take)))
        else $error("evict sweep outside held pages");
`endif

endmodule

/* bench/fpr_checker.sv */
// checker for the fifo page replacement block: tracks resident pages and compares every result
`timescale 1ns / 100ps
module fpr_checker
    import fpr_pkg::*;
#(
    parameter int FRAMES = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_item,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_item,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int PRINT_CAP = 50;

    t_slot resident[$];
    t_out  due_results[$];
    int    fail_count = 0;
    int    pending_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic note_mismatch(input string what, input int got, input int want);
        if (fail_count < PRINT_CAP) begin
            $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
        end
        fail_count++;
    endtask

    function automatic int find_page(input logic [15:0] page);
        foreach (resident[i]) begin
            if (resident[i].page_id == page) return i;
        end
        return -1;
    endfunction

    task automatic predict_results(input t_in req);
        int      pos;
        int      take;
        t_status st;
        t_slot   entry;
        t_out    res;
        t_out    batch[$];
        st  = ST_OK;
        pos = find_page(req.page_id);
        case (req.op)
            OP_INSERT: begin
                if (pos >= 0) begin
                    st = ST_DUP;
                end else if (resident.size() >= FRAMES) begin
                    st = ST_FULL;
                end else begin
                    entry.page_id     = req.page_id;
                    entry.frame_index = req.frame_index;
                    resident = {resident, entry};
                end
            end
            OP_REMOVE: begin
                if (pos < 0) begin
                    st = ST_ABSENT;
                end else begin
                    resident.delete(pos);
                end
            end
            OP_EVICT: begin
                take = req.count;
                if (take > resident.size()) take = resident.size();
                if (take > MAX_RESULTS) take = MAX_RESULTS;
                for (int k = 0; k < take; k++) begin
                    entry             = resident[0];
                    resident.delete(0);
                    res               = '0;
                    res.evicted_frame = entry.frame_index;
                    res.has_frame     = 1'b1;
                    res.last          = (k == take - 1);
                    res.status        = ST_OK;
                    batch = {batch, res};
                end
            end
            default: ;
        endcase
        if (batch.size() == 0) begin
            res        = '0;
            res.last   = 1'b1;
            res.status = st;
            batch = {batch, res};
        end
        foreach (batch[k]) begin
            batch[k].occupancy = 5'(resident.size());
            due_results = {due_results, batch[k]};
        end
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (due_results.size() == 0) begin
            note_mismatch("result with nothing expected, frame", got.evicted_frame, 0);
            return;
        end
        want = due_results[0];
        due_results.delete(0);
        if (got.evicted_frame !== want.evicted_frame)
            note_mismatch("evicted_frame", got.evicted_frame, want.evicted_frame);
        if (got.has_frame !== want.has_frame)
            note_mismatch("has_frame", got.has_frame, want.has_frame);
        if (got.last !== want.last)
            note_mismatch("last", got.last, want.last);
        if (got.status !== want.status)
            note_mismatch("status", got.status, want.status);
        if (got.occupancy !== want.occupancy)
            note_mismatch("occupancy", got.occupancy, want.occupancy);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) check_result(i_out_item);
            if (i_in_valid && !i_in_stall) predict_results(i_in_item);
            pending_count = due_results.size();
        end
    end

endmodule

/* bench/tb_fifo_page_replacement.sv */
// testbench top for the fifo page replacement block: stimulus, handshake pressure and verdict
`timescale 1ns / 100ps
module tb_fifo_page_replacement;
    import fpr_pkg::*;

    localparam int FRAMES       = 16;
    localparam int RANDOM_ITEMS = 145;
    localparam int CALM_ITEMS   = 40;
    localparam int FLOOD_ITEMS  = 24;
    localparam int LONG_HOLD    = 160;
    localparam int IDLE_PERCENT = 34;
    localparam int POOL_SIZE    = 24;
    localparam int STALL_LIMIT  = 3000;
    localparam int TAIL_CYCLES  = 60;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_item   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_item;
    int   fail_count;
    int   pending;

    logic        calm       = 1'b0;
    logic        flood_req  = 1'b0;
    logic        flood_done = 1'b0;
    logic [15:0] page_pool[POOL_SIZE];
    int          quiet_cycles = 0;

    always #5 clk = ~clk;

    fifo_page_replacement #(
        .FRAMES(FRAMES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item)
    );

    fpr_checker #(
        .FRAMES(FRAMES)
    ) results_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_item   (in_item),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_item  (out_item),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    function automatic logic idle_now();
        return !calm && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    function automatic t_in make_req(input t_op op, input logic [15:0] page,
                                     input logic [3:0] frame, input logic [4:0] count);
        t_in req;
        req.op          = op;
        req.page_id     = page;
        req.frame_index = frame;
        req.count       = count;
        return req;
    endfunction

    function automatic t_in random_request();
        t_in req;
        int  roll;
        req  = '0;
        roll = $urandom_range(99);
        if (roll < 45) req.op = OP_INSERT;
        else if (roll < 65) req.op = OP_REMOVE;
        else if (roll < 85) req.op = OP_EVICT;
        else req.op = OP_ACCESS;
        req.page_id = ($urandom_range(99) < 80) ? page_pool[$urandom_range(POOL_SIZE - 1)]
                                                : 16'($urandom);
        req.frame_index = 4'($urandom);
        req.count = ($urandom_range(99) < 70) ? 5'($urandom_range(4)) : 5'($urandom_range(31));
        return req;
    endfunction

    task automatic send_item(input t_in req);
        while (idle_now()) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= req;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off while the sender floods
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge clk);
            if (flood_req && !flood_done && hold_left == 0) hold_left = LONG_HOLD;
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
                if (hold_left == 0) flood_done = 1'b1;
            end else begin
                out_stall <= idle_now();
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        int k;
        foreach (page_pool[i]) page_pool[i] = 16'($urandom);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list, absent page, access, duplicate and zero count
        send_item(make_req(OP_EVICT, 16'h0000, 4'h0, 5'd5));
        send_item(make_req(OP_REMOVE, 16'hFFFF, 4'h0, 5'd0));
        send_item(make_req(OP_ACCESS, 16'hABCD, 4'hF, 5'd31));
        send_item(make_req(OP_INSERT, 16'h0000, 4'h0, 5'd0));
        send_item(make_req(OP_INSERT, 16'hFFFF, 4'hF, 5'd0));
        send_item(make_req(OP_INSERT, 16'h0000, 4'h7, 5'd0));
        send_item(make_req(OP_EVICT, 16'h0000, 4'h0, 5'd0));
        send_item(make_req(OP_REMOVE, 16'hFFFF, 4'h0, 5'd0));
        // fill up, refuse one more, take one from the middle, then over-ask on evict
        for (k = 1; k < FRAMES; k++) begin
            send_item(make_req(OP_INSERT, 16'(k * 16'h1111), 4'(k), 5'd0));
        end
        send_item(make_req(OP_INSERT, 16'h1234, 4'h3, 5'd0));
        send_item(make_req(OP_REMOVE, 16'h7777, 4'h0, 5'd0));
        send_item(make_req(OP_EVICT, 16'h0000, 4'h0, 5'd31));

        calm = 1'b1;
        for (k = 0; k < CALM_ITEMS; k++) send_item(random_request());

        flood_req = 1'b1;
        for (k = 0; k < FLOOD_ITEMS; k++) send_item(random_request());
        calm = 1'b0;

        wait_drained();
        for (k = CALM_ITEMS + FLOOD_ITEMS; k < RANDOM_ITEMS; k++) send_item(random_request());

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/fpr_pkg.sv
hw/rtl/fifo_page_replacement.sv
bench/fpr_checker.sv
bench/tb_fifo_page_replacement.sv
